[rtl/mpct_pkg.sv]
// Shared definitions for the mouse packet cursor tracker.
// Holds field widths, register indexes, click codes and packet constants.
// Used by all modules in the rtl folder; depends on nothing else.
package mpct_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int PTR_W    = 8;
    localparam int CLICK_W  = 2;
    localparam int LEN_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTER_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINTER_HEIGHT = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0] RST_PACKET_LENGTH  = 3'd3;
    localparam logic [POS_W-1:0] RST_SCREEN_WIDTH   = 12'd640;
    localparam logic [POS_W-1:0] RST_SCREEN_HEIGHT  = 12'd480;
    localparam logic [PTR_W-1:0] RST_POINTER_WIDTH  = 8'd0;
    localparam logic [PTR_W-1:0] RST_POINTER_HEIGHT = 8'd0;

    // A length register value at or above this selects 4-byte packets.
    localparam logic [LEN_W-1:0] LEN_WHEEL = 3'd4;

    // Bits of the first packet byte
    localparam int SYNC_BIT  = 3;
    localparam int LEFT_BIT  = 0;
    localparam int RIGHT_BIT = 1;

    // Byte positions within a packet
    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_DX     = 2'd1;
    localparam logic [1:0] POS_DY     = 2'd2;
    localparam logic [1:0] POS_WHEEL  = 2'd3;

    // Click codes
    localparam logic [CLICK_W-1:0] CLICK_NONE  = 2'd0;
    localparam logic [CLICK_W-1:0] CLICK_LEFT  = 2'd1;
    localparam logic [CLICK_W-1:0] CLICK_RIGHT = 2'd2;

endpackage

[rtl/mpct_axis_clamp.sv]
// One cursor axis: adds a signed byte delta and clamps to the visible range.
// Depends on mpct_pkg for widths.
module mpct_axis_clamp (
    input  logic [mpct_pkg::POS_W-1:0]        pos,
    input  logic signed [mpct_pkg::BYTE_W-1:0] delta,
    input  logic [mpct_pkg::POS_W-1:0]        screen,
    input  logic [mpct_pkg::PTR_W-1:0]        ptr,
    output logic [mpct_pkg::POS_W-1:0]        pos_new
);
    import mpct_pkg::*;

    logic signed [POS_W+1:0] sum;
    logic signed [POS_W+1:0] limit;
    logic signed [POS_W:0]   lim_raw;

    // Upper limit is screen minus pointer, never below zero.
    assign lim_raw = $signed({1'b0, screen}) - $signed({{(POS_W-PTR_W+1){1'b0}}, ptr});
    assign limit   = lim_raw[POS_W] ? '0 : {1'b0, lim_raw};

    // Moved position, wide enough for any sign.
    assign sum = $signed({2'b00, pos}) + {{(POS_W+2-BYTE_W){delta[BYTE_W-1]}}, delta};

    // Clamp to zero below and to the limit above.
    always_comb begin
        priority if (sum[POS_W+1]) begin
            pos_new = '0;
        end else if (sum > limit) begin
            pos_new = limit[POS_W-1:0];
        end else begin
            pos_new = sum[POS_W-1:0];
        end
    end

endmodule

[rtl/mouse_packet_cursor_tracker.sv]
// Top level of the mouse packet cursor tracker.
// Depends on mpct_pkg and mpct_axis_clamp.
//
// Takes one mouse byte per word on the s_ channel and assembles 3- or
// 4-byte packets; while no packet is under way, bytes with bit 3 clear are
// dropped to resynchronize. Each completed packet yields one word on the
// m_ channel with the clamped cursor position, the click code and the
// wheel byte. A byte is taken every cycle unless the input stalls: it lands
// in an input register, and combinational decode, add and clamp move a
// packet-completing byte from there into the output register.
// The input stalls only while a packet-completing byte waits in the input
// register and the output register still holds a result that the receiver
// has not taken.
// Configuration writes are always ready and should only be issued while no
// byte is in flight.
module mouse_packet_cursor_tracker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mpct_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mpct_pkg::POS_W-1:0]        m_cursor_x,
    output logic [mpct_pkg::POS_W-1:0]        m_cursor_y,
    output logic [mpct_pkg::CLICK_W-1:0]      m_click,
    output logic signed [mpct_pkg::BYTE_W-1:0] m_wheel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mpct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mpct_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mpct_pkg::*;

    // Configuration registers
    logic [LEN_W-1:0] packet_length_reg;
    logic [POS_W-1:0] screen_width_reg;
    logic [POS_W-1:0] screen_height_reg;
    logic [PTR_W-1:0] pointer_width_reg;
    logic [PTR_W-1:0] pointer_height_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Packet state
    logic [1:0]        byte_index_reg;
    logic [1:0]        byte_index_next;
    logic [BYTE_W-1:0] packet_bytes_reg [3];
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_y_reg;

    // Output register
    logic                      out_valid_reg;
    logic [POS_W-1:0]          out_x_reg;
    logic [POS_W-1:0]          out_y_reg;
    logic [CLICK_W-1:0]        out_click_reg;
    logic signed [BYTE_W-1:0]  out_wheel_reg;

    // Decode signals
    logic                     len4;
    logic                     drop;
    logic                     complete;
    logic                     store;
    logic                     advance;
    logic [BYTE_W-1:0]        b0;
    logic [BYTE_W-1:0]        b1;
    logic [BYTE_W-1:0]        b2;
    logic signed [BYTE_W-1:0] dx;
    logic signed [BYTE_W-1:0] dy;
    logic [POS_W-1:0]         new_x;
    logic [POS_W-1:0]         new_y;
    logic [CLICK_W-1:0]       click;
    logic [BYTE_W-1:0]        wheel;

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_length_reg  <= RST_PACKET_LENGTH;
            screen_width_reg   <= RST_SCREEN_WIDTH;
            screen_height_reg  <= RST_SCREEN_HEIGHT;
            pointer_width_reg  <= RST_POINTER_WIDTH;
            pointer_height_reg <= RST_POINTER_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PACKET_LENGTH:  packet_length_reg  <= cfg_data[LEN_W-1:0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data[POS_W-1:0];
                REG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_data[POS_W-1:0];
                REG_POINTER_WIDTH:  pointer_width_reg  <= cfg_data[PTR_W-1:0];
                REG_POINTER_HEIGHT: pointer_height_reg <= cfg_data[PTR_W-1:0];
                default: ;
            endcase
        end
    end

    // Packet position decode for the byte in the input register.
    assign len4 = (packet_length_reg >= LEN_WHEEL);
    assign drop = (byte_index_reg == POS_HEADER) && !in_byte_reg[SYNC_BIT];
    assign complete = !drop && (len4 ? (byte_index_reg == POS_WHEEL)
                                     : (byte_index_reg >= POS_DY));
    assign store = !drop && !complete;

    // The byte moves on unless a result is due and the output is blocked.
    assign advance = in_valid_reg && (!complete || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        byte_index_next = byte_index_reg;
        if (complete) begin
            byte_index_next = POS_HEADER;
        end else if (store) begin
            byte_index_next = byte_index_reg + 2'd1;
        end
    end

    // Assemble packet fields; the current byte may stand in for the dy byte.
    assign b0 = packet_bytes_reg[POS_HEADER];
    assign b1 = packet_bytes_reg[POS_DX];
    assign b2 = (byte_index_reg == POS_DY) ? in_byte_reg : packet_bytes_reg[POS_DY];
    assign dx = $signed(b1);
    assign dy = $signed(~b2 + 8'd1);
    assign wheel = (len4 && byte_index_reg == POS_WHEEL) ? in_byte_reg : '0;

    // Left button wins over right.
    always_comb begin
        priority if (b0[LEFT_BIT]) begin
            click = CLICK_LEFT;
        end else if (b0[RIGHT_BIT]) begin
            click = CLICK_RIGHT;
        end else begin
            click = CLICK_NONE;
        end
    end

    mpct_axis_clamp u_clamp_x (
        .pos     (pos_x_reg),
        .delta   (dx),
        .screen  (screen_width_reg),
        .ptr     (pointer_width_reg),
        .pos_new (new_x)
    );

    mpct_axis_clamp u_clamp_y (
        .pos     (pos_y_reg),
        .delta   (dy),
        .screen  (screen_height_reg),
        .ptr     (pointer_height_reg),
        .pos_new (new_y)
    );

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Packet index and cursor state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= POS_HEADER;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
        end else if (advance) begin
            byte_index_reg <= byte_index_next;
            if (complete) begin
                pos_x_reg <= new_x;
                pos_y_reg <= new_y;
            end
        end
    end

    // Stored packet bytes need no reset.
    always_ff @(posedge aclk) begin
        if (advance && store && byte_index_reg != POS_WHEEL) begin
            packet_bytes_reg[byte_index_reg] <= in_byte_reg;
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && complete) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && complete) begin
            out_x_reg     <= new_x;
            out_y_reg     <= new_y;
            out_click_reg <= click;
            out_wheel_reg <= $signed(wheel);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_cursor_x = out_x_reg;
    assign m_cursor_y = out_y_reg;
    assign m_click    = out_click_reg;
    assign m_wheel    = out_wheel_reg;

endmodule

[bench/testbench.sv]
// Testbench for the mouse packet cursor tracker: a directed table of mouse bytes and register
// writes, then randomized phases; results are checked against pinned rows or a built-in tracker.
// Depends on mpct_pkg and mouse_packet_cursor_tracker from the rtl folder.
`timescale 1ns / 1ps

module testbench;
    import mpct_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    // A result passes the input and then the output register after the byte that completes a packet.
    localparam int DRAIN_CYCLES    = 4;
    localparam int IDLE_LIMIT      = 3000;
    localparam int PRESSURE_AT     = 600;
    localparam int HOLD_CYCLES     = 400;

    typedef struct {
        logic [POS_W-1:0]         x;
        logic [POS_W-1:0]         y;
        logic [CLICK_W-1:0]       click;
        logic signed [BYTE_W-1:0] wheel;
    } cursor_report_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                pinned;
        cursor_report_t    report;
    } mouse_word_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] value;
        mouse_word_t           word;
    } plan_row_t;

    typedef enum {RX_STEADY, RX_MOSTLY, RX_EVERY_THIRD, RX_SPARSE} rx_pattern_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [BYTE_W-1:0] s_rx_byte;
    logic m_valid;
    logic m_ready;
    logic [POS_W-1:0] m_cursor_x;
    logic [POS_W-1:0] m_cursor_y;
    logic [CLICK_W-1:0] m_click;
    logic signed [BYTE_W-1:0] m_wheel;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mouse_packet_cursor_tracker dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cursor_x (m_cursor_x),
        .m_cursor_y (m_cursor_y),
        .m_click    (m_click),
        .m_wheel    (m_wheel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Tracker mirror: register copies, packet assembly state and cursor.
    logic [LEN_W-1:0]  trk_len;
    logic [POS_W-1:0]  trk_scr_w;
    logic [POS_W-1:0]  trk_scr_h;
    logic [PTR_W-1:0]  trk_ptr_w;
    logic [PTR_W-1:0]  trk_ptr_h;
    logic [1:0]        trk_idx;
    logic [BYTE_W-1:0] trk_bytes [3];
    logic [POS_W-1:0]  trk_x;
    logic [POS_W-1:0]  trk_y;

    mouse_word_t    outgoing_bytes [$];
    cursor_report_t expected_reports [$];
    mouse_word_t    on_wire;
    bit             word_accepted;
    int             bytes_taken;
    int             error_count;
    int             idle_cycles;

    // Clock.
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Mismatch reporting: one line per problem.
    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Clamp one axis to 0..(screen - pointer), with a negative limit taken as 0.
    function automatic logic [POS_W-1:0] clamp_axis_pos(input logic [POS_W-1:0] pos,
                                                        input int delta,
                                                        input logic [POS_W-1:0] scr,
                                                        input logic [PTR_W-1:0] ptr);
        int lim;
        int moved;
        lim = int'(scr) - int'(ptr);
        moved = int'(pos) + delta;
        if (lim < 0)
            lim = 0;
        if (moved < 0)
            moved = 0;
        if (moved > lim)
            moved = lim;
        return moved[POS_W-1:0];
    endfunction

    // Feed one accepted byte to the mirror; done is set when it completes a packet.
    task automatic advance_tracker(input logic [BYTE_W-1:0] b, output bit done,
                                   output cursor_report_t rep);
        int                plen;
        logic [1:0]        idx;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] dxb;
        logic [BYTE_W-1:0] dyb;
        logic [BYTE_W-1:0] negdy;
        plen = (trk_len >= LEN_WHEEL) ? 4 : 3;
        idx = trk_idx;
        done = 1'b0;
        rep = '{POS_W'(0), POS_W'(0), CLICK_NONE, 8'sd0};
        if (idx == POS_HEADER && !b[SYNC_BIT]) begin
            // Out of sync: drop the byte.
        end else if (idx + 1 < plen) begin
            if (idx < 3)
                trk_bytes[idx] = b;
            trk_idx = idx + 2'd1;
        end else begin
            // The current byte is the last one; a shortened packet reuses stored bytes.
            trk_idx = POS_HEADER;
            hdr = trk_bytes[POS_HEADER];
            dxb = trk_bytes[POS_DX];
            dyb = (idx == POS_DY) ? b : trk_bytes[POS_DY];
            negdy = 8'd0 - dyb;
            trk_x = clamp_axis_pos(trk_x, int'($signed(dxb)), trk_scr_w, trk_ptr_w);
            trk_y = clamp_axis_pos(trk_y, int'($signed(negdy)), trk_scr_h, trk_ptr_h);
            rep.x = trk_x;
            rep.y = trk_y;
            if (hdr[LEFT_BIT])
                rep.click = CLICK_LEFT;
            else if (hdr[RIGHT_BIT])
                rep.click = CLICK_RIGHT;
            else
                rep.click = CLICK_NONE;
            rep.wheel = (plen == 4 && idx == POS_WHEEL) ? $signed(b) : 8'sd0;
            done = 1'b1;
        end
    endtask

    // Wait until no byte is queued or in flight and every result has come back.
    task automatic wait_idle();
        while (outgoing_bytes.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write, issued only once the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        unique case (idx)
            REG_PACKET_LENGTH:  trk_len = val[LEN_W-1:0];
            REG_SCREEN_WIDTH:   trk_scr_w = val[POS_W-1:0];
            REG_SCREEN_HEIGHT:  trk_scr_h = val[POS_W-1:0];
            REG_POINTER_WIDTH:  trk_ptr_w = val[PTR_W-1:0];
            REG_POINTER_HEIGHT: trk_ptr_h = val[PTR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        mouse_word_t w;
        w.data = b;
        w.pinned = 1'b0;
        w.report = '{POS_W'(0), POS_W'(0), CLICK_NONE, 8'sd0};
        outgoing_bytes.push_back(w);
    endtask

    // Deltas lean toward the signed extremes so the clamps get exercised.
    function automatic logic [BYTE_W-1:0] pick_delta();
        unique case ($urandom_range(0, 7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h81;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Builders for the directed table.
    function automatic plan_row_t byte_row(input logic [BYTE_W-1:0] b);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.reg_index = REG_PACKET_LENGTH;
        row.value = '0;
        row.word.data = b;
        row.word.pinned = 1'b0;
        row.word.report = '{POS_W'(0), POS_W'(0), CLICK_NONE, 8'sd0};
        return row;
    endfunction

    function automatic plan_row_t pinned_row(input logic [BYTE_W-1:0] b,
                                             input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [CLICK_W-1:0] click,
                                             input logic signed [BYTE_W-1:0] wheel);
        plan_row_t row;
        row = byte_row(b);
        row.word.pinned = 1'b1;
        row.word.report = '{x, y, click, wheel};
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = byte_row(8'h00);
        row.is_cfg = 1'b1;
        row.reg_index = idx;
        row.value = val;
        return row;
    endfunction

    // Byte sender: bursts of random length separated by random gaps.
    initial begin : byte_sender
        int gap_left;
        int burst_left;
        s_valid = 1'b0;
        s_rx_byte = '0;
        word_accepted = 1'b0;
        gap_left = 0;
        burst_left = 1;
        forever begin
            @(negedge aclk);
            if (!s_valid || word_accepted) begin
                word_accepted = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (outgoing_bytes.size() > 0) begin
                    on_wire = outgoing_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_rx_byte <= on_wire.data;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: changing stall patterns, plus one long hold-off to fill the block.
    initial begin : result_receiver
        rx_pattern_t pattern;
        int          pattern_left;
        int          hold_left;
        bit          pressure_done;
        m_ready = 1'b0;
        pattern = RX_STEADY;
        pattern_left = 0;
        hold_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!pressure_done && bytes_taken >= PRESSURE_AT) begin
                hold_left = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (pattern_left == 0) begin
                pattern = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(40, 160);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                unique case (pattern)
                    RX_STEADY:      m_ready <= 1'b1;
                    RX_MOSTLY:      m_ready <= ($urandom_range(0, 9) < 7);
                    RX_EVERY_THIRD: m_ready <= (pattern_left % 3 == 0);
                    default:        m_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Accepted bytes go through the mirror; completed packets queue an expectation.
    always @(posedge aclk) begin
        bit             done;
        cursor_report_t rep;
        if (aresetn && s_valid && s_ready) begin
            word_accepted = 1'b1;
            bytes_taken++;
            advance_tracker(on_wire.data, done, rep);
            if (done)
                expected_reports.push_back(on_wire.pinned ? on_wire.report : rep);
        end
    end

    // Accepted results are checked field by field against the oldest expectation.
    always @(posedge aclk) begin
        cursor_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                flag_error($sformatf("unexpected result x=%0d y=%0d click=%0d wheel=%0d",
                                     m_cursor_x, m_cursor_y, m_click, m_wheel));
            end else begin
                want = expected_reports.pop_front();
                if (m_cursor_x !== want.x)
                    flag_error($sformatf("cursor_x %0d, wanted %0d", m_cursor_x, want.x));
                if (m_cursor_y !== want.y)
                    flag_error($sformatf("cursor_y %0d, wanted %0d", m_cursor_y, want.y));
                if (m_click !== want.click)
                    flag_error($sformatf("click %0d, wanted %0d", m_click, want.click));
                if (m_wheel !== want.wheel)
                    flag_error($sformatf("wheel %0d, wanted %0d", m_wheel, want.wheel));
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin : stimulus
        plan_row_t         directed_plan [$];
        plan_row_t         row;
        logic [CFG_DATA_W-1:0] setting [5];
        logic [BYTE_W-1:0] hdr;
        int                phase;
        int                queued;
        int                plen;
        int                n;

        error_count = 0;
        bytes_taken = 0;
        idle_cycles = 0;
        cfg_valid = 1'b0;
        cfg_index = REG_PACKET_LENGTH;
        cfg_data = '0;
        aresetn = 1'b0;

        trk_len = RST_PACKET_LENGTH;
        trk_scr_w = RST_SCREEN_WIDTH;
        trk_scr_h = RST_SCREEN_HEIGHT;
        trk_ptr_w = RST_POINTER_WIDTH;
        trk_ptr_h = RST_POINTER_HEIGHT;
        trk_idx = POS_HEADER;
        trk_bytes[0] = '0;
        trk_bytes[1] = '0;
        trk_bytes[2] = '0;
        trk_x = '0;
        trk_y = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from the reset settings (3 bytes, 640 x 480).
        // Bytes out of sync are dropped.
        directed_plan.push_back(byte_row(8'h00));
        directed_plan.push_back(byte_row(8'hF7));
        // Largest dx; dy of -128 stays -128 after negation and clamps at 0.
        directed_plan.push_back(byte_row(8'h08));
        directed_plan.push_back(byte_row(8'h7F));
        directed_plan.push_back(pinned_row(8'h80, 12'd127, 12'd0, CLICK_NONE, 8'sd0));
        directed_plan.push_back(byte_row(8'h09));
        directed_plan.push_back(byte_row(8'h7F));
        directed_plan.push_back(pinned_row(8'h81, 12'd254, 12'd127, CLICK_LEFT, 8'sd0));
        // Left wins over right; most negative dx.
        directed_plan.push_back(byte_row(8'h0B));
        directed_plan.push_back(byte_row(8'h80));
        directed_plan.push_back(pinned_row(8'h7F, 12'd126, 12'd0, CLICK_LEFT, 8'sd0));
        directed_plan.push_back(byte_row(8'h0A));
        directed_plan.push_back(byte_row(8'h00));
        directed_plan.push_back(pinned_row(8'h00, 12'd126, 12'd0, CLICK_RIGHT, 8'sd0));
        // Wheel packets.
        directed_plan.push_back(reg_row(REG_PACKET_LENGTH, CFG_DATA_W'(LEN_WHEEL)));
        directed_plan.push_back(byte_row(8'h08));
        directed_plan.push_back(byte_row(8'h01));
        directed_plan.push_back(byte_row(8'hFF));
        directed_plan.push_back(pinned_row(8'h80, 12'd127, 12'd1, CLICK_NONE, -8'sd128));
        // Length lowered after three bytes: the next byte closes the packet.
        directed_plan.push_back(byte_row(8'h08));
        directed_plan.push_back(byte_row(8'h05));
        directed_plan.push_back(byte_row(8'h02));
        directed_plan.push_back(reg_row(REG_PACKET_LENGTH, 12'd3));
        directed_plan.push_back(pinned_row(8'h7F, 12'd132, 12'd0, CLICK_NONE, 8'sd0));
        // Length above 4 acts as 4; pointer wider than the screen pins x at 0.
        directed_plan.push_back(reg_row(REG_PACKET_LENGTH, 12'd7));
        directed_plan.push_back(reg_row(REG_SCREEN_WIDTH, 12'd10));
        directed_plan.push_back(reg_row(REG_POINTER_WIDTH, 12'd255));
        directed_plan.push_back(byte_row(8'h0C));
        directed_plan.push_back(byte_row(8'h7F));
        directed_plan.push_back(byte_row(8'h01));
        directed_plan.push_back(byte_row(8'h7F));

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_cfg)
                write_register(row.reg_index, row.value);
            else
                outgoing_bytes.push_back(row.word);
        end

        // Random phases, each under its own register settings.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: setting = '{12'd0, 12'd0, 12'd1, 12'd0, 12'd0};
                1: setting = '{12'd7, 12'd4095, 12'd4095, 12'd255, 12'd255};
                2: setting = '{12'd4, 12'd1, 12'd4095, 12'd255, 12'd0};
                default: begin
                    setting[0] = CFG_DATA_W'($urandom_range(0, 7));
                    setting[1] = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, 4095) : $urandom_range(64, 700));
                    setting[2] = CFG_DATA_W'(($urandom_range(0, 3) == 0) ?
                                 $urandom_range(0, 4095) : $urandom_range(64, 700));
                    setting[3] = CFG_DATA_W'($urandom_range(0, 255));
                    setting[4] = CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            write_register(REG_PACKET_LENGTH, setting[0]);
            write_register(REG_SCREEN_WIDTH, setting[1]);
            write_register(REG_SCREEN_HEIGHT, setting[2]);
            write_register(REG_POINTER_WIDTH, setting[3]);
            write_register(REG_POINTER_HEIGHT, setting[4]);

            queued = 0;
            while (queued < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) begin
                    // Well-formed packet with random content.
                    plen = (trk_len >= LEN_WHEEL) ? 4 : 3;
                    hdr = BYTE_W'($urandom_range(0, 255));
                    hdr[SYNC_BIT] = 1'b1;
                    queue_byte(hdr);
                    queue_byte(pick_delta());
                    queue_byte(pick_delta());
                    if (plen == 4)
                        queue_byte(BYTE_W'($urandom_range(0, 255)));
                    queued += plen;
                end else begin
                    // Noise and broken packets.
                    n = $urandom_range(1, 3);
                    repeat (n) queue_byte(BYTE_W'($urandom_range(0, 255)));
                    queued += n;
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_reports.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_reports.size()));

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
